@@ hdl/okt_pkg.sv @@
// Shared constants, operation and status codes, and cell interface types
// for the ordered key table. No dependencies.
`default_nettype none
package okt_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 31;
  localparam int ID_W  = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_REM  = 3'd1;
  localparam logic [2:0] OP_NEAR = 3'd2;
  localparam logic [2:0] OP_MIN  = 3'd3;
  localparam logic [2:0] OP_MAX  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_ID   = 3'd1;
  localparam logic [2:0] ST_NEG_KEY = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [KEY_W-1:0]    key;
    logic [ID_W-1:0]     id;
    logic                neg;
    logic [KEY_W-1:0]    chosen;
  } bcast_t;

  typedef struct packed {
    logic ins;
    logic pre;
    logic ge;
    logic bnd;
    logic hit;
  } cell_flags_t;

endpackage
`default_nettype wire

@@ hdl/okt_cell.sv @@
// One cell of the sorted chain: holds a key and an id, compares them with the
// broadcast request, and shifts with its neighbors. Depends on okt_pkg.
`default_nettype none
module okt_cell (
  input  wire logic                        clk,
  input  wire okt_pkg::bcast_t             bc,
  input  wire logic                        occ,
  input  wire logic                        left_occ,
  input  wire logic [okt_pkg::KEY_W-1:0]   left_key,
  input  wire logic [okt_pkg::ID_W-1:0]    left_id,
  input  wire okt_pkg::cell_flags_t        left_fl,
  input  wire logic [okt_pkg::KEY_W-1:0]   right_key,
  input  wire logic [okt_pkg::ID_W-1:0]    right_id,
  output logic [okt_pkg::KEY_W-1:0]        key,
  output logic [okt_pkg::ID_W-1:0]         id,
  output okt_pkg::cell_flags_t             fl
);

  logic [okt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [okt_pkg::ID_W-1:0]  id_r, id_nxt;
  logic                      match;
  logic                      head;

  always_comb begin
    match  = occ && !bc.neg && (key_r == bc.key) && (id_r == bc.id);
    head   = occ && (!left_occ || (left_key != key_r));
    fl.ins = !occ || (key_r > bc.key);
    fl.pre = match || left_fl.pre;
    fl.ge  = occ && (bc.neg || (key_r >= bc.key));
    fl.bnd = fl.ge && !left_fl.ge;
    fl.hit = head && (key_r == bc.chosen);
  end

  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    case (bc.cmd)
      okt_pkg::CMD_INS: begin
        if (fl.ins) begin
          if (left_fl.ins) begin
            key_nxt = left_key;
            id_nxt  = left_id;
          end else begin
            key_nxt = bc.key;
            id_nxt  = bc.id;
          end
        end
      end
      okt_pkg::CMD_DEL: begin
        if (fl.pre) begin
          key_nxt = right_key;
          id_nxt  = right_id;
        end
      end
      default: begin
        key_nxt = key_r;
        id_nxt  = id_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

  assign key = key_r;
  assign id  = id_r;

endmodule
`default_nettype wire

@@ hdl/ordered_key_table_nearest.sv @@
// Top level of the ordered key table: request decoder, sequencer and the
// chain of okt_cell instances. Depends on okt_pkg and okt_cell.
// The result strobe is registered: add, rejected or unknown requests and
// queries on an empty table end in S_EXEC; nearest, min and max go
// through S_EXEC, S_SCAN, S_PICK and S_FETCH; a remove goes through S_EXEC
// and S_REM, one deletion per cycle through the chain. busy drops in the
// strobe cycle, so the next request can start then, and not before. The
// receiver cannot stall. Reset empties the table at once; no clearing pass.
`default_nettype none
module ordered_key_table_nearest (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  in_op,
  input  wire logic signed [31:0]          in_key,
  input  wire logic [okt_pkg::ID_W-1:0]    in_entry_id,
  output logic                             out_strobe,
  output logic [2:0]                       out_status,
  output logic                             out_found,
  output logic [okt_pkg::KEY_W-1:0]        out_result_key,
  output logic [okt_pkg::ID_W-1:0]         out_result_id
);

  localparam int DEPTH = okt_pkg::DEPTH;
  localparam int KEY_W = okt_pkg::KEY_W;
  localparam int ID_W  = okt_pkg::ID_W;
  localparam int CNT_W = okt_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_REM   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_PICK  = 6'b010000,
    S_FETCH = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    found_r, found_nxt;
  logic [2:0]              op_r, op_nxt;
  logic signed [31:0]      key_r, key_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [KEY_W-1:0]        hi_r, hi_nxt;
  logic [KEY_W-1:0]        lo_r, lo_nxt;
  logic                    have_lo_r, have_lo_nxt;
  logic [KEY_W-1:0]        chosen_r, chosen_nxt;
  logic                    strobe_r, strobe_nxt;
  logic [2:0]              status_r, status_nxt;
  logic                    ofound_r, ofound_nxt;
  logic [KEY_W-1:0]        okey_r, okey_nxt;
  logic [ID_W-1:0]         oid_r, oid_nxt;

  okt_pkg::bcast_t         bc;
  okt_pkg::cell_cmd_t      cmd;
  logic [KEY_W-1:0]        ckey [DEPTH];
  logic [ID_W-1:0]         cid  [DEPTH];
  okt_pkg::cell_flags_t    fl   [DEPTH];
  logic                    occ  [DEPTH];
  logic [KEY_W-1:0]        lkey [DEPTH];

  logic                    any_ge;
  logic                    any_lo;
  logic [KEY_W-1:0]        hi_sel;
  logic [KEY_W-1:0]        lo_sel;
  logic [KEY_W-1:0]        hit_key;
  logic [ID_W-1:0]         hit_id;
  logic [KEY_W-1:0]        dist_lo;
  logic [KEY_W-1:0]        dist_hi;
  logic                    last;
  logic                    pick;

  assign bc.cmd    = cmd;
  assign bc.key    = key_r[KEY_W-1:0];
  assign bc.id     = id_r;
  assign bc.neg    = key_r[31];
  assign bc.chosen = chosen_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = (CNT_W'(g) < cnt_r);
    if (g == 0) begin : g_first
      assign lkey[g] = '0;
      okt_cell u_cell (
        .clk       (clk),
        .bc        (bc),
        .occ       (occ[g]),
        .left_occ  (1'b0),
        .left_key  (lkey[g]),
        .left_id   ('0),
        .left_fl   ('0),
        .right_key (ckey[g+1]),
        .right_id  (cid[g+1]),
        .key       (ckey[g]),
        .id        (cid[g]),
        .fl        (fl[g])
      );
    end else if (g == DEPTH - 1) begin : g_last
      assign lkey[g] = ckey[g-1];
      okt_cell u_cell (
        .clk       (clk),
        .bc        (bc),
        .occ       (occ[g]),
        .left_occ  (occ[g-1]),
        .left_key  (lkey[g]),
        .left_id   (cid[g-1]),
        .left_fl   (fl[g-1]),
        .right_key (ckey[g]),
        .right_id  (cid[g]),
        .key       (ckey[g]),
        .id        (cid[g]),
        .fl        (fl[g])
      );
    end else begin : g_mid
      assign lkey[g] = ckey[g-1];
      okt_cell u_cell (
        .clk       (clk),
        .bc        (bc),
        .occ       (occ[g]),
        .left_occ  (occ[g-1]),
        .left_key  (lkey[g]),
        .left_id   (cid[g-1]),
        .left_fl   (fl[g-1]),
        .right_key (ckey[g+1]),
        .right_id  (cid[g+1]),
        .key       (ckey[g]),
        .id        (cid[g]),
        .fl        (fl[g])
      );
    end
  end

  // Bucket selection: for nearest, the high candidate is the lower-bound cell
  // (or the last cell when every key is below the target), the low candidate
  // its left neighbor; min and max take the first or the last cell.
  always_comb begin
    any_ge  = 1'b0;
    any_lo  = 1'b0;
    hi_sel  = '0;
    lo_sel  = '0;
    hit_key = '0;
    hit_id  = '0;
    last    = 1'b0;
    pick    = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_ge = any_ge | fl[i].ge;
    end
    for (int i = 0; i < DEPTH; i++) begin
      last = (cnt_r == CNT_W'(i + 1));
      case (op_r)
        okt_pkg::OP_MIN: pick = (i == 0);
        okt_pkg::OP_MAX: pick = last;
        default:         pick = fl[i].bnd || (last && !any_ge);
      endcase
      if (pick) begin
        hi_sel = hi_sel | ckey[i];
      end
      if ((i > 0) && fl[i].bnd) begin
        lo_sel = lo_sel | lkey[i];
        any_lo = 1'b1;
      end
      if (fl[i].hit) begin
        hit_key = hit_key | ckey[i];
        hit_id  = hit_id | cid[i];
      end
    end
  end

  assign dist_lo = key_r[KEY_W-1:0] - lo_r;
  assign dist_hi = hi_r - key_r[KEY_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    id_nxt      = id_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    have_lo_nxt = have_lo_r;
    chosen_nxt  = chosen_r;
    cmd         = okt_pkg::CMD_HOLD;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    ofound_nxt  = ofound_r;
    okey_nxt    = okey_r;
    oid_nxt     = oid_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          id_nxt    = in_entry_id;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_IDLE;
        ofound_nxt = 1'b0;
        okey_nxt   = '0;
        oid_nxt    = '0;
        status_nxt = okt_pkg::ST_OK;
        case (op_r)
          okt_pkg::OP_ADD: begin
            strobe_nxt = 1'b1;
            if (id_r == '0) begin
              status_nxt = okt_pkg::ST_NO_ID;
            end else if (key_r[31]) begin
              status_nxt = okt_pkg::ST_NEG_KEY;
            end else if (cnt_r == CNT_W'(DEPTH)) begin
              status_nxt = okt_pkg::ST_FULL;
            end else begin
              cmd     = okt_pkg::CMD_INS;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          okt_pkg::OP_REM: begin
            found_nxt = 1'b0;
            state_nxt = S_REM;
          end
          okt_pkg::OP_NEAR, okt_pkg::OP_MIN, okt_pkg::OP_MAX: begin
            if (cnt_r == '0) begin
              strobe_nxt = 1'b1;
              status_nxt = okt_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            strobe_nxt = 1'b1;
          end
        endcase
      end
      S_REM: begin
        if (fl[DEPTH-1].pre) begin
          cmd       = okt_pkg::CMD_DEL;
          cnt_nxt   = cnt_r - CNT_W'(1);
          found_nxt = 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = okt_pkg::ST_OK;
          ofound_nxt = found_r;
          okey_nxt   = '0;
          oid_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        hi_nxt      = hi_sel;
        lo_nxt      = lo_sel;
        have_lo_nxt = any_lo && (op_r == okt_pkg::OP_NEAR);
        state_nxt   = S_PICK;
      end
      S_PICK: begin
        chosen_nxt = (have_lo_r && (dist_lo < dist_hi)) ? lo_r : hi_r;
        state_nxt  = S_FETCH;
      end
      S_FETCH: begin
        strobe_nxt = 1'b1;
        status_nxt = okt_pkg::ST_OK;
        ofound_nxt = 1'b1;
        okey_nxt   = hit_key;
        oid_nxt    = hit_id;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    id_r      <= id_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    have_lo_r <= have_lo_nxt;
    chosen_r  <= chosen_nxt;
    status_r  <= status_nxt;
    ofound_r  <= ofound_nxt;
    okey_r    <= okey_nxt;
    oid_r     <= oid_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_found      = ofound_r;
  assign out_result_key = okey_r;
  assign out_result_id  = oid_r;

endmodule
`default_nettype wire

@@ hdl/okt_chk.sv @@
// Port-level checker for the ordered key table and its bind to the top level.
// Depends on okt_pkg and ordered_key_table_nearest.
`default_nettype none
module okt_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [2:0] out_status,
  input wire logic       out_found
);

  // An accepted request keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Results come only from a request that was in progress.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result strobe without a request in progress");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  // A rejected or empty-table result never reports an entry.
  a_fail_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != okt_pkg::ST_OK)) |-> !out_found)
    else $error("failed request reports a found entry");

endmodule

bind ordered_key_table_nearest okt_chk u_okt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_status (out_status),
  .out_found  (out_found)
);
`default_nettype wire
